// ----- sv/sfa_pkg.sv -----
// Package for the sprite frame animator: field widths, mode codes, defaults
// and the control structs shared by the sequencer, the cells and the top level.
// No dependencies.
package sfa_pkg;

    localparam int IDX_W     = 5;
    localparam int FRAME_W   = 6;
    localparam int SPEED_W   = 8;
    localparam int MODE_W    = 2;
    localparam int STEP_W    = 16;
    localparam int CD_W      = 18;

    localparam int SPRITES_DEF     = 32;
    localparam int MAX_CATCHUP_DEF = 16;
    localparam int REPORT_LIMIT    = 32;

    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              start;
        logic              catchup;
        logic              copy;
        logic              shift;
        logic [STEP_W-1:0] step;
    } t_cell_ctl;

    // settings written into one cell by a load item
    typedef struct packed {
        logic [FRAME_W-1:0] frames;
        logic [SPEED_W-1:0] speed;
        logic [MODE_W-1:0]  mode;
    } t_load;

endpackage

// ----- sv/sfa_if.sv -----
// Handshake interfaces for the sprite frame animator: input items and results.
// Depends on sfa_pkg for the field widths.
interface sfa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [sfa_pkg::IDX_W-1:0]   sprite_index;
    logic [sfa_pkg::FRAME_W-1:0] frame_count;
    logic [sfa_pkg::SPEED_W-1:0] speed_ticks;
    logic [sfa_pkg::MODE_W-1:0]  anim_mode;
    logic [sfa_pkg::STEP_W-1:0]  step_time;

    modport source (output valid, op, sprite_index, frame_count, speed_ticks,
                    anim_mode, step_time, input ready);
    modport sink   (input valid, op, sprite_index, frame_count, speed_ticks,
                    anim_mode, step_time, output ready);
endinterface

interface sfa_out_if;
    logic                        valid;
    logic                        ready;
    logic [sfa_pkg::IDX_W-1:0]   sprite_number;
    logic [sfa_pkg::FRAME_W-1:0] frame_shown;
    logic                        last_of_run;

    modport source (output valid, sprite_number, frame_shown, last_of_run,
                    input ready);
    modport sink   (input valid, sprite_number, frame_shown, last_of_run,
                    output ready);
endinterface

// ----- sv/sfa_cell.sv -----
// One sprite cell: settings, frame, direction and countdown of one sprite,
// plus one stage of the report shift chain. Depends on sfa_pkg.
module sfa_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfa_pkg::t_cell_ctl          i_ctl,
    input  logic                        i_load_sel,
    input  sfa_pkg::t_load              i_load,
    input  logic [sfa_pkg::FRAME_W-1:0] i_next_rpt,
    output logic [sfa_pkg::FRAME_W-1:0] o_rpt
);

    logic [sfa_pkg::FRAME_W-1:0] r_frames, n_frames;
    logic [sfa_pkg::SPEED_W-1:0] r_speed,  n_speed;
    logic [sfa_pkg::MODE_W-1:0]  r_mode,   n_mode;
    logic [sfa_pkg::FRAME_W-1:0] r_frame,  n_frame;
    logic                        r_rev,    n_rev;
    logic signed [sfa_pkg::CD_W-1:0] r_cd, n_cd;
    logic                        r_busy,   n_busy;
    logic [sfa_pkg::FRAME_W-1:0] r_rpt,    n_rpt;

    logic [sfa_pkg::FRAME_W-1:0]     w_sf;
    logic                            w_sr;
    logic signed [sfa_pkg::CD_W-1:0] w_add;
    logic signed [sfa_pkg::CD_W-1:0] w_cd_step;

    // sprite animates at all in this state
    function automatic logic f_active(input logic [sfa_pkg::MODE_W-1:0]  mode,
                                      input logic [sfa_pkg::FRAME_W-1:0] f,
                                      input logic [sfa_pkg::FRAME_W-1:0] n);
        logic r;
        r = 1'b1;
        if (mode == sfa_pkg::MODE_NONE) begin
            r = 1'b0;
        end else if (mode == sfa_pkg::MODE_ONESHOT) begin
            r = ({1'b0, f} + 7'd1) < {1'b0, n};
        end
        return r;
    endfunction

    function automatic logic f_pos(input logic signed [sfa_pkg::CD_W-1:0] c);
        return (c > 0);
    endfunction

    // frame step: advance, wrap or turn
    always_comb begin
        w_sf = r_frame;
        w_sr = r_rev;
        if (!r_rev) begin
            if (({1'b0, r_frame} + 7'd1) < {1'b0, r_frames}) begin
                w_sf = r_frame + 6'd1;
            end else if (r_mode == sfa_pkg::MODE_PINGPONG) begin
                if (r_frames >= 6'd2) begin
                    w_sr = 1'b1;
                    w_sf = (r_frame > 6'd0) ? r_frame - 6'd1 : 6'd0;
                end else begin
                    w_sf = 6'd0;
                end
            end else begin
                w_sf = 6'd0;
            end
        end else begin
            if (r_frame > 6'd0) begin
                w_sf = r_frame - 6'd1;
            end else begin
                w_sr = 1'b0;
                w_sf = (r_frames >= 6'd2) ? 6'd1 : 6'd0;
            end
        end
    end

    assign w_add     = $signed({2'b00, r_speed, 8'h00});
    assign w_cd_step = r_cd + w_add;

    // load, first look at a tick, catch-up steps, report chain
    always_comb begin
        n_frames = r_frames;
        n_speed  = r_speed;
        n_mode   = r_mode;
        n_frame  = r_frame;
        n_rev    = r_rev;
        n_cd     = r_cd;
        n_busy   = r_busy;
        n_rpt    = r_rpt;
        if (i_load_sel) begin
            n_frames = i_load.frames;
            n_speed  = i_load.speed;
            n_mode   = i_load.mode;
            n_frame  = '0;
            n_rev    = 1'b0;
            n_cd     = $signed({2'b00, i_load.speed, 8'h00});
        end else if (i_ctl.start) begin
            n_busy = 1'b0;
            if (f_active(r_mode, r_frame, r_frames)) begin
                if (f_pos(r_cd)) begin
                    n_cd = r_cd - $signed({2'b00, i_ctl.step});
                end else begin
                    n_busy = 1'b1;
                end
            end
        end else if (i_ctl.catchup && r_busy) begin
            n_frame = w_sf;
            n_rev   = w_sr;
            n_cd    = w_cd_step;
            n_busy  = !f_pos(w_cd_step) && f_active(r_mode, w_sf, r_frames)
                      && (r_speed != '0);
        end
        if (i_ctl.copy) begin
            n_rpt = r_frame;
        end else if (i_ctl.shift) begin
            n_rpt = i_next_rpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
            r_speed  <= '0;
            r_mode   <= sfa_pkg::MODE_NONE;
            r_frame  <= '0;
            r_rev    <= 1'b0;
            r_cd     <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_frames <= n_frames;
            r_speed  <= n_speed;
            r_mode   <= n_mode;
            r_frame  <= n_frame;
            r_rev    <= n_rev;
            r_cd     <= n_cd;
            r_busy   <= n_busy;
        end
    end

    // report stage: payload only
    always_ff @(posedge i_clk) begin
        r_rpt <= n_rpt;
    end

    assign o_rpt = r_rpt;

endmodule

// ----- sv/sfa_ctrl.sv -----
// Sequencer of the sprite frame animator: input handshake, catch-up
// iteration count, report copy and result handshake. Depends on sfa_pkg.
module sfa_ctrl #(
    parameter int SPRITES     = sfa_pkg::SPRITES_DEF,
    parameter int MAX_CATCHUP = sfa_pkg::MAX_CATCHUP_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_op,
    input  logic [sfa_pkg::STEP_W-1:0] i_step,
    output logic                       o_in_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [sfa_pkg::IDX_W-1:0]  o_num,
    output logic                       o_last,
    output sfa_pkg::t_cell_ctl         o_ctl
);

    localparam int ITER_W  = (MAX_CATCHUP > 1) ? $clog2(MAX_CATCHUP) : 1;
    localparam int RPT_CNT = (SPRITES < sfa_pkg::REPORT_LIMIT) ? SPRITES
                                                                : sfa_pkg::REPORT_LIMIT;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CATCH = 2'd1;
    localparam logic [1:0] S_COPY  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [ITER_W-1:0]        r_iter,  n_iter;
    logic [sfa_pkg::IDX_W-1:0] r_num,  n_num;

    logic w_tick;
    logic w_last;
    logic w_iter_end;

    assign w_tick     = i_in_valid && o_in_ready && (i_op == sfa_pkg::OP_TICK);
    assign w_last     = (r_num == sfa_pkg::IDX_W'(RPT_CNT - 1));
    assign w_iter_end = (r_iter == ITER_W'(MAX_CATCHUP - 1));

    // advance through catch-up, copy and report
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_num   = r_num;
        case (r_state)
            S_IDLE: begin
                if (w_tick) begin
                    n_state = S_CATCH;
                    n_iter  = '0;
                end
            end
            S_CATCH: begin
                n_iter = r_iter + 1'b1;
                if (w_iter_end) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                n_state = S_OUT;
                n_num   = '0;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_num = r_num + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_num   <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_num   <= n_num;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_num       = r_num;
    assign o_last      = w_last;

    always_comb begin
        o_ctl.start   = w_tick;
        o_ctl.catchup = (r_state == S_CATCH);
        o_ctl.copy    = (r_state == S_COPY);
        o_ctl.shift   = (r_state == S_OUT) && i_out_ready;
        o_ctl.step    = i_step;
    end

endmodule

// ----- sv/sprite_frame_animator.sv -----
// Top level of the sprite frame animator: sequencer and a row of sprite cells.
// Depends on sfa_pkg, sfa_if, sfa_ctrl and sfa_cell.
//
//  channel | direction | payload
//  i_in    | in        | op, sprite_index, frame_count, speed_ticks, anim_mode, step_time
//  o_out   | out       | sprite_number, frame_shown, last_of_run
//
// A load item gives no result. A tick item is accepted, then the
// sequencer runs MAX_CATCHUP catch-up steps in which the cells that are
// due step in parallel, copies the frames into the report chain, and then
// shifts min(SPRITES,32) results out of the chain, one per accepted result.
// Synchronous active-low reset clears all sprite state. A stalled result
// holds the chain; no input item is taken until the last result has gone.
module sprite_frame_animator #(
    parameter int SPRITES     = sfa_pkg::SPRITES_DEF,
    parameter int MAX_CATCHUP = sfa_pkg::MAX_CATCHUP_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sfa_in_if.sink  i_in,
    sfa_out_if.source o_out
);

    sfa_pkg::t_cell_ctl          w_ctl;
    sfa_pkg::t_load              w_load;
    logic                        w_load_en;
    logic [sfa_pkg::FRAME_W-1:0] w_rpt [SPRITES];

    sfa_ctrl #(
        .SPRITES     (SPRITES),
        .MAX_CATCHUP (MAX_CATCHUP)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .i_step      (i_in.step_time),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_num       (o_out.sprite_number),
        .o_last      (o_out.last_of_run),
        .o_ctl       (w_ctl)
    );

    // decode a load; an index past the table is dropped
    assign w_load_en = i_in.valid && i_in.ready && (i_in.op == sfa_pkg::OP_LOAD)
                       && ({2'b00, i_in.sprite_index} < 7'(SPRITES));

    always_comb begin
        w_load.frames = i_in.frame_count;
        w_load.speed  = i_in.speed_ticks;
        w_load.mode   = i_in.anim_mode;
    end

    // row of cells; reports shift towards cell 0
    for (genvar k = 0; k < SPRITES; k++) begin : g_cell
        logic [sfa_pkg::FRAME_W-1:0] w_next;
        if (k == SPRITES - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_rpt[k+1];
        end
        sfa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_load_sel (w_load_en && ({1'b0, i_in.sprite_index} == 6'(k))),
            .i_load     (w_load),
            .i_next_rpt (w_next),
            .o_rpt      (w_rpt[k])
        );
    end

    assign o_out.frame_shown = w_rpt[0];

    // results and input acceptance never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input ready while a result is offered");

    // a tick is followed by catch-up, not by a result
    a_tick_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.op) |=> !o_out.valid)
        else $error("result offered straight after a tick");

    // the last result of a run returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_of_run) |=> i_in.ready)
        else $error("block not idle after the last result");

    // the first result of a run reports sprite 0
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !$past(o_out.valid)) |-> (o_out.sprite_number == '0))
        else $error("run does not start at sprite 0");

endmodule
